// ----- src/vnh_pkg.sv -----
// Shared types, constants and arithmetic helpers for the value-noise height field core.
// No dependencies; imported by every module of the block.
package vnh_pkg;

    localparam int COORD_W    = 16;           // grid coordinate width
    localparam int FREQ_W     = 16;           // Q0.16 frequency width
    localparam int FRAC_W     = 16;           // fraction bits of a position
    localparam int PROD_W     = COORD_W + FREQ_W + 1;
    localparam int HASH_W     = 29;           // low bits of the hash sum that reach the result
    localparam int NOISE_W    = 16;
    localparam int BYTE_W     = 8;
    localparam int HEIGHT_W   = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PIPE_DEPTH = 8;

    localparam logic [HASH_W-1:0]  HASH_MUL_X   = HASH_W'(374761393);
    localparam logic [HASH_W-1:0]  HASH_MUL_Z   = HASH_W'(668265263);
    localparam logic [NOISE_W-1:0] HASH_MUL_MIX = NOISE_W'(1274126177);
    localparam int                 HASH_SHIFT   = 13;

    localparam logic [FREQ_W-1:0] FREQ_RST = FREQ_W'(7864);
    localparam logic [BYTE_W-1:0] BASE_RST = BYTE_W'(5);
    localparam logic [BYTE_W-1:0] AMP_RST  = BYTE_W'(11);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREQUENCY = 2'd0,
        CFG_BASE      = 2'd1,
        CFG_AMPLITUDE = 2'd2
    } t_cfg_idx;

    // Per-stage load enables and valid bits, stage 1 next to the input.
    typedef struct packed {
        logic [PIPE_DEPTH:1] en;
        logic [PIPE_DEPTH:1] vld;
    } t_pipe_ctl;

    // floor((p*(1-s) + q*s)) in Q0.16
    function automatic logic [NOISE_W-1:0] lerp_q16(input logic [NOISE_W-1:0] p,
                                                   input logic [NOISE_W-1:0] q,
                                                   input logic [NOISE_W-1:0] s);
        logic [NOISE_W:0]     inv;
        logic [2*NOISE_W:0]   acc;
        inv = (NOISE_W+1)'(1 << NOISE_W) - {1'b0, s};
        acc = p * inv + q * s;
        return acc[2*NOISE_W-1:NOISE_W];
    endfunction

endpackage

// ----- src/value_noise_height_field_core.sv -----
// Value-noise height field core: 2D value noise to terrain height, eight-stage pipeline.
// Depends on vnh_pkg, vnh_pipe_ctl, vnh_smooth and vnh_corner_hash.
//
// Each accepted item (i_coord_x, i_coord_z) yields one o_height, in the order of
// acceptance. One item enters per cycle while o_stall is low; the
// pipeline has eight register stages: position multiply, cell hash products and
// fraction square, hash xor-shift and smoothstep product, hash final multiply, row
// mix, column mix, amplitude multiply, and the divide by 65535 plus base add. Each
// stage advances whenever it is empty or its content moves on, so bubbles collapse
// and new items are taken while a finished height waits in the output register.
// o_stall is combinational from i_stall and the stage valid bits. Configuration
// registers (frequency, base, amplitude) act on items as they flow through, so write
// them only while no item is in flight. Register index 3 is ignored.
module value_noise_height_field_core import vnh_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // input items
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_z,
    // result items
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [HEIGHT_W-1:0]    o_height
);

    t_pipe_ctl ctl;

    logic [FREQ_W-1:0] r_freq;
    logic [BYTE_W-1:0] r_base;
    logic [BYTE_W-1:0] r_amp;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= FREQ_RST;
            r_base <= BASE_RST;
            r_amp  <= AMP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FREQUENCY: r_freq <= i_cfg_wdata[FREQ_W-1:0];
                CFG_BASE:      r_base <= i_cfg_wdata[BYTE_W-1:0];
                CFG_AMPLITUDE: r_amp  <= i_cfg_wdata[BYTE_W-1:0];
                default:       ;
            endcase
        end
    end

    vnh_pipe_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_ctl   (ctl)
    );

    assign o_stall = !ctl.en[1];
    assign o_valid = ctl.vld[PIPE_DEPTH];

    // Stage 1: exact signed position in Q.16
    logic signed [FREQ_W:0]   freq_s;
    logic signed [PROD_W-1:0] r_px;
    logic signed [PROD_W-1:0] r_pz;

    assign freq_s = $signed({1'b0, r_freq});

    always_ff @(posedge i_clk) begin
        if (ctl.en[1]) begin
            r_px <= i_coord_x * freq_s;
            r_pz <= i_coord_z * freq_s;
        end
    end

    // Stage 2: floor to cell, neighbor cell, per-axis hash products
    logic [HASH_W-1:0] cell_x0;
    logic [HASH_W-1:0] cell_x1;
    logic [HASH_W-1:0] cell_z0;
    logic [HASH_W-1:0] cell_z1;
    logic [HASH_W-1:0] r_xa0;
    logic [HASH_W-1:0] r_xa1;
    logic [HASH_W-1:0] r_zb0;
    logic [HASH_W-1:0] r_zb1;

    assign cell_x0 = HASH_W'(r_px >>> FRAC_W);
    assign cell_z0 = HASH_W'(r_pz >>> FRAC_W);
    assign cell_x1 = cell_x0 + HASH_W'(1);
    assign cell_z1 = cell_z0 + HASH_W'(1);

    always_ff @(posedge i_clk) begin
        if (ctl.en[2]) begin
            r_xa0 <= cell_x0 * HASH_MUL_X;
            r_xa1 <= cell_x1 * HASH_MUL_X;
            r_zb0 <= cell_z0 * HASH_MUL_Z;
            r_zb1 <= cell_z1 * HASH_MUL_Z;
        end
    end

    // Stages 2-3: smoothstep weights
    logic [NOISE_W-1:0] sx3;
    logic [NOISE_W-1:0] sz3;

    vnh_smooth u_smooth_x (
        .i_clk    (i_clk),
        .i_en_sq  (ctl.en[2]),
        .i_en_out (ctl.en[3]),
        .i_frac   (r_px[FRAC_W-1:0]),
        .o_smooth (sx3)
    );

    vnh_smooth u_smooth_z (
        .i_clk    (i_clk),
        .i_en_sq  (ctl.en[2]),
        .i_en_out (ctl.en[3]),
        .i_frac   (r_pz[FRAC_W-1:0]),
        .o_smooth (sz3)
    );

    // Stages 3-4: hash the four corners
    logic [NOISE_W-1:0] h00;
    logic [NOISE_W-1:0] h10;
    logic [NOISE_W-1:0] h01;
    logic [NOISE_W-1:0] h11;

    vnh_corner_hash u_hash_00 (
        .i_clk (i_clk), .i_en_mix (ctl.en[3]), .i_en_out (ctl.en[4]),
        .i_x_term (r_xa0), .i_z_term (r_zb0), .o_hash (h00)
    );
    vnh_corner_hash u_hash_10 (
        .i_clk (i_clk), .i_en_mix (ctl.en[3]), .i_en_out (ctl.en[4]),
        .i_x_term (r_xa1), .i_z_term (r_zb0), .o_hash (h10)
    );
    vnh_corner_hash u_hash_01 (
        .i_clk (i_clk), .i_en_mix (ctl.en[3]), .i_en_out (ctl.en[4]),
        .i_x_term (r_xa0), .i_z_term (r_zb1), .o_hash (h01)
    );
    vnh_corner_hash u_hash_11 (
        .i_clk (i_clk), .i_en_mix (ctl.en[3]), .i_en_out (ctl.en[4]),
        .i_x_term (r_xa1), .i_z_term (r_zb1), .o_hash (h11)
    );

    // Stage 4: hold the weights alongside the hashes; stage 5 holds the z weight again
    logic [NOISE_W-1:0] r_sx4;
    logic [NOISE_W-1:0] r_sz4;
    logic [NOISE_W-1:0] r_sz5;
    logic [NOISE_W-1:0] r_row_a;
    logic [NOISE_W-1:0] r_row_b;
    logic [NOISE_W-1:0] r_noise;
    logic [NOISE_W+BYTE_W-1:0] r_scaled;
    logic [HEIGHT_W-1:0] r_height;

    // divide by 65535: floor(y/65535) == (y + (y >> 16) + 1) >> 16 for y below 65535*256
    logic [NOISE_W+BYTE_W:0] div_sum;
    logic [BYTE_W-1:0]       quot;

    assign div_sum = {1'b0, r_scaled}
                   + {{(NOISE_W+1){1'b0}}, r_scaled[NOISE_W+BYTE_W-1:NOISE_W]}
                   + (NOISE_W+BYTE_W+1)'(1);
    assign quot    = div_sum[NOISE_W+BYTE_W-1:NOISE_W];

    always_ff @(posedge i_clk) begin
        if (ctl.en[4]) begin
            r_sx4 <= sx3;
            r_sz4 <= sz3;
        end
        // Stage 5: mix along x for both rows
        if (ctl.en[5]) begin
            r_row_a <= lerp_q16(h00, h10, r_sx4);
            r_row_b <= lerp_q16(h01, h11, r_sx4);
            r_sz5   <= r_sz4;
        end
        // Stage 6: mix the rows along z
        if (ctl.en[6]) begin
            r_noise <= lerp_q16(r_row_a, r_row_b, r_sz5);
        end
        // Stage 7: scale by amplitude
        if (ctl.en[7]) begin
            r_scaled <= r_noise * r_amp;
        end
        // Stage 8: divide and add base into the output register
        if (ctl.en[8]) begin
            r_height <= {1'b0, r_base} + {1'b0, quot};
        end
    end

    assign o_height = r_height;

    // An empty output register never backs up the input side.
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output register");

    // Scaled noise never exceeds the amplitude.
    a_height_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_height <= ({1'b0, r_base} + {1'b0, r_amp})))
        else $error("height above base plus amplitude");

    // Zero amplitude leaves only the base.
    a_zero_amp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_amp == '0)) |-> (o_height == {1'b0, r_base}))
        else $error("height differs from base at zero amplitude");

endmodule

// ----- src/vnh_pipe_ctl.sv -----
// Valid tracking and per-stage load enables for the height pipeline.
// Depends on vnh_pkg.
module vnh_pipe_ctl import vnh_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic      i_stall,
    output t_pipe_ctl o_ctl
);

    logic [PIPE_DEPTH:1]   r_v;
    logic [PIPE_DEPTH:1]   n_v;
    logic [PIPE_DEPTH+1:1] en;

    // a stage loads when it is empty or its content moves on; bubbles collapse
    always_comb begin
        en[PIPE_DEPTH+1] = !i_stall;
        for (int k = PIPE_DEPTH; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_comb begin
        n_v = r_v;
        if (en[1]) begin
            n_v[1] = i_valid;
        end
        for (int k = 2; k <= PIPE_DEPTH; k++) begin
            if (en[k]) begin
                n_v[k] = r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_ctl.en  = en[PIPE_DEPTH:1];
    assign o_ctl.vld = r_v;

endmodule

// ----- src/vnh_smooth.sv -----
// Two-stage smoothstep t*t*(3-2t) on a Q0.16 fraction.
// Depends on vnh_pkg.
module vnh_smooth import vnh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en_sq,
    input  logic               i_en_out,
    input  logic [FRAC_W-1:0]  i_frac,
    output logic [NOISE_W-1:0] o_smooth
);

    logic [2*FRAC_W-1:0]   r_sq;
    logic [FRAC_W+1:0]     r_w;
    logic [NOISE_W-1:0]    r_s;
    logic [3*FRAC_W+1:0]   prod;

    assign prod = r_sq * r_w;

    always_ff @(posedge i_clk) begin
        if (i_en_sq) begin
            r_sq <= i_frac * i_frac;
            r_w  <= (FRAC_W+2)'(3 << FRAC_W) - {1'b0, i_frac, 1'b0};
        end
        if (i_en_out) begin
            r_s <= prod[2*FRAC_W+NOISE_W-1:2*FRAC_W];
        end
    end

    assign o_smooth = r_s;

endmodule

// ----- src/vnh_corner_hash.sv -----
// Two-stage corner hash: sum and xor-shift, then the final multiply, low 16 bits.
// Depends on vnh_pkg; takes the per-axis products from the top level.
module vnh_corner_hash import vnh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en_mix,
    input  logic               i_en_out,
    input  logic [HASH_W-1:0]  i_x_term,
    input  logic [HASH_W-1:0]  i_z_term,
    output logic [NOISE_W-1:0] o_hash
);

    logic [HASH_W-1:0]  sum;
    logic [NOISE_W-1:0] r_mix;
    logic [NOISE_W-1:0] r_hash;

    assign sum = i_x_term + i_z_term;

    always_ff @(posedge i_clk) begin
        if (i_en_mix) begin
            r_mix <= sum[NOISE_W-1:0] ^ sum[HASH_SHIFT+NOISE_W-1:HASH_SHIFT];
        end
        if (i_en_out) begin
            r_hash <= r_mix * HASH_MUL_MIX;
        end
    end

    assign o_hash = r_hash;

endmodule
